>>> src/ms_pkg.sv
// shared constants and types for the max stack block
package ms_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned IN_VAL_W    = 32;
  localparam int unsigned OUT_VAL_W   = 32;
  localparam int unsigned DEPTH_W     = 11;
  localparam int unsigned ERR_W       = 2;

  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned OUT_DATA_W  = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_TOP     = 3'd2,
    CMD_PEEKMAX = 3'd3,
    CMD_POPMAX  = 3'd4
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;

endpackage

>>> src/max_stack_core.sv
// max stack top level: storage, scan and shift sequencer, output register
// push, errors and unknown commands go from idle straight to the output stage; pop and top first read the top entry
// peek maximum: scans the held entries from the top down, one entry per cycle through the read port
// pop maximum: the top entry goes directly if it is the maximum, else the entries above it shift down to close the gap
// one item at a time; the next beat is taken the cycle after the result enters the output register
// reset clears the element count and control state; stack memory contents are not cleared
module max_stack_core
  import ms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // command[2:0], value[34:3], zero fill
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // result_value[31:0], depth_after[42:32],
                                                  // error_code[44:43], zero fill
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_SHIFT_START,
    ST_SHIFT,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    count_q;
  cmd_e                cmd_q;
  word_t               res_q;
  err_e                err_q;
  word_t               best_q;
  logic [ADDR_W-1:0]   best_idx_q;
  logic [ADDR_W-1:0]   data_addr_q;
  logic [ADDR_W-1:0]   wr_addr_q;
  logic                first_q;

  logic                  m_valid_q;
  logic [OUT_VAL_W-1:0]  m_val_q;
  logic [DEPTH_W-1:0]    m_depth_q;
  err_e                  m_err_q;

  word_t               mem_q [STACK_DEPTH];
  word_t               rdata_q;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  word_t               wr_data;

  logic                in_beat;
  cmd_e                in_cmd;
  word_t               in_val;
  logic [ADDR_W-1:0]   top_addr;
  logic                take;
  word_t               best_d;
  logic [ADDR_W-1:0]   best_idx_d;
  logic                shift_last;
  logic                out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cmd   = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign in_val   = s_axis_tdata_i[CMD_W +: IN_VAL_W];
  assign top_addr = ADDR_W'(count_q - CNT_W'(1));

  assign take       = first_q || (rdata_q > best_q);
  assign best_d     = take ? rdata_q : best_q;
  assign best_idx_d = take ? data_addr_q : best_idx_q;
  assign shift_last = ({1'b0, wr_addr_q} == CNT_W'(count_q - CNT_W'(2)));
  assign out_free   = !m_valid_q || m_axis_tready_i;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = top_addr;
    wr_en   = 1'b0;
    wr_addr = top_addr;
    wr_data = in_val;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_cmd == CMD_PUSH) begin
            wr_en   = (count_q != CNT_W'(STACK_DEPTH));
            wr_addr = count_q[ADDR_W-1:0];
          end else if (count_q != '0 && (in_cmd == CMD_POP || in_cmd == CMD_TOP ||
                                         in_cmd == CMD_PEEKMAX || in_cmd == CMD_POPMAX)) begin
            rd_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        rd_en   = (data_addr_q != '0);
        rd_addr = data_addr_q - ADDR_W'(1);
      end
      ST_SHIFT_START: begin
        rd_en   = 1'b1;
        rd_addr = best_idx_q + ADDR_W'(1);
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = wr_addr_q;
        wr_data = rdata_q;
        rd_en   = !shift_last;
        rd_addr = wr_addr_q + ADDR_W'(2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      m_valid_q   <= 1'b0;
      cmd_q       <= CMD_PUSH;
      res_q       <= '0;
      err_q       <= ERR_OK;
      best_q      <= '0;
      best_idx_q  <= '0;
      data_addr_q <= '0;
      wr_addr_q   <= '0;
      first_q     <= 1'b0;
      m_val_q     <= '0;
      m_depth_q   <= '0;
      m_err_q     <= ERR_OK;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != ST_FIN) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            cmd_q <= in_cmd;
            res_q <= '0;
            case (in_cmd)
              CMD_PUSH: begin
                state_q <= ST_FIN;
                if (count_q == CNT_W'(STACK_DEPTH)) begin
                  err_q <= ERR_FULL;
                end else begin
                  err_q   <= ERR_OK;
                  count_q <= count_q + CNT_W'(1);
                end
              end
              CMD_POP, CMD_TOP, CMD_PEEKMAX, CMD_POPMAX: begin
                if (count_q == '0) begin
                  err_q   <= ERR_EMPTY;
                  state_q <= ST_FIN;
                end else if (in_cmd == CMD_POP || in_cmd == CMD_TOP) begin
                  err_q   <= ERR_OK;
                  state_q <= ST_READ;
                end else begin
                  err_q       <= ERR_OK;
                  data_addr_q <= top_addr;
                  first_q     <= 1'b1;
                  state_q     <= ST_SCAN;
                end
              end
              default: begin
                err_q   <= ERR_OK;
                state_q <= ST_FIN;
              end
            endcase
          end
        end
        ST_READ: begin
          res_q <= rdata_q;
          if (cmd_q == CMD_POP) begin
            count_q <= count_q - CNT_W'(1);
          end
          state_q <= ST_FIN;
        end
        ST_SCAN: begin
          best_q      <= best_d;
          best_idx_q  <= best_idx_d;
          first_q     <= 1'b0;
          data_addr_q <= data_addr_q - ADDR_W'(1);
          if (data_addr_q == '0) begin
            res_q <= best_d;
            if (cmd_q == CMD_POPMAX && best_idx_d != top_addr) begin
              state_q <= ST_SHIFT_START;
            end else begin
              if (cmd_q == CMD_POPMAX) begin
                count_q <= count_q - CNT_W'(1);
              end
              state_q <= ST_FIN;
            end
          end
        end
        ST_SHIFT_START: begin
          wr_addr_q <= best_idx_q;
          state_q   <= ST_SHIFT;
        end
        ST_SHIFT: begin
          wr_addr_q <= wr_addr_q + ADDR_W'(1);
          if (shift_last) begin
            count_q <= count_q - CNT_W'(1);
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_val_q   <= OUT_VAL_W'(res_q);
            m_depth_q <= DEPTH_W'(count_q);
            m_err_q   <= err_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_VAL_W - DEPTH_W - ERR_W){1'b0}},
                            m_err_q, m_depth_q, m_val_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("element count above stack depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == ST_SHIFT) |-> ({1'b0, wr_addr_q} < count_q - CNT_W'(1)))
    else $error("shift writes at or above the top entry");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_cmd == CMD_PUSH && count_q != CNT_W'(STACK_DEPTH))
    |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("push did not grow the stack");

  a_fin_holds_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_free) |=> (state_q == ST_FIN))
    else $error("result dropped while output register busy");

endmodule
